[sv/jhds_pkg.sv]
package jhds_pkg;

	localparam int COUNT_BITS_DEF = 24;
	localparam int IMAGE_BYTES_W  = 24;
	localparam int DATA_W         = 32;
	localparam int ADDR_W         = 3;

	// Register index taken from paddr[2]
	localparam logic REG_IMAGE_BYTES = 1'b0;

	localparam logic [15:0] MARK_SOI       = 16'hFFD8;
	localparam logic [15:0] MARK_EOI       = 16'hFFD9;
	localparam logic [15:0] MARK_FRAME_LO  = 16'hFFC0;
	localparam logic [15:0] MARK_FRAME_HI  = 16'hFFCF;
	localparam logic [15:0] MARK_DHT       = 16'hFFC4;
	localparam logic [15:0] MARK_JPG       = 16'hFFC8;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_of_image;
	} in_t;

	typedef struct packed {
		logic        found;
		logic [15:0] height;
		logic [15:0] width;
	} out_t;

	function automatic logic is_frame_marker(input logic [15:0] m);
		return (m >= MARK_FRAME_LO) && (m <= MARK_FRAME_HI) &&
			(m != MARK_DHT) && (m != MARK_JPG);
	endfunction

endpackage

[sv/jhds_parser.sv]
module jhds_parser #(
	parameter int COUNT_BITS = jhds_pkg::COUNT_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  jhds_pkg::in_t                        item,
	input  logic [jhds_pkg::IMAGE_BYTES_W-1:0]   image_bytes,
	output logic                                 res_valid,
	output jhds_pkg::out_t                       res
);

	localparam logic [3:0] PH_IDLE = 4'd0;
	localparam logic [3:0] PH_MHI  = 4'd1;
	localparam logic [3:0] PH_MLO  = 4'd2;
	localparam logic [3:0] PH_LHI  = 4'd3;
	localparam logic [3:0] PH_LLO  = 4'd4;
	localparam logic [3:0] PH_PREC = 4'd5;
	localparam logic [3:0] PH_HHI  = 4'd6;
	localparam logic [3:0] PH_HLO  = 4'd7;
	localparam logic [3:0] PH_WHI  = 4'd8;
	localparam logic [3:0] PH_WLO  = 4'd9;
	localparam logic [3:0] PH_SKIP = 4'd10;

	localparam int EXT_W = ((COUNT_BITS > jhds_pkg::IMAGE_BYTES_W) ?
		COUNT_BITS : jhds_pkg::IMAGE_BYTES_W) + 1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic [3:0]            phase_q, phase_n, phase_base;
	logic [COUNT_BITS-1:0] count_q, count_n, count_base, count_inc;
	logic [15:0]           skip_q, skip_n, skip_dec, len_word, len_skip;
	logic [15:0]           marker_q, marker_n;
	logic [7:0]            hold_q, hold_n;
	logic [15:0]           height_q, height_n;
	logic [EXT_W-1:0]      inc_ext, ib_ext;
	logic                  start, start_exh, boundary, bound_exh, data_end;

	assign start      = item.first_of_image;
	assign ib_ext     = EXT_W'(image_bytes);
	assign start_exh  = (EXT_W'(2) >= ib_ext);
	assign count_base = start ? '0 : count_q;
	assign phase_base = start ? PH_MHI : phase_q;
	assign count_inc  = (count_base == COUNT_MAX) ? count_base : count_base + 1'b1;
	assign inc_ext    = EXT_W'(count_inc);
	// count >= image_bytes-2, and always true when image_bytes < 2
	assign bound_exh  = (inc_ext + EXT_W'(2)) >= ib_ext;
	assign data_end   = inc_ext >= ib_ext;
	assign len_word   = {hold_q, item.data_byte};
	assign len_skip   = (len_word >= 16'd2) ? len_word - 16'd2 : 16'd0;
	assign skip_dec   = skip_q - 16'd1;

	always_comb begin
		phase_n   = phase_q;
		count_n   = count_q;
		skip_n    = skip_q;
		marker_n  = marker_q;
		hold_n    = hold_q;
		height_n  = height_q;
		res_valid = 1'b0;
		res       = '0;
		boundary  = 1'b0;
		if (start) begin
			count_n = '0;
			skip_n  = '0;
			phase_n = PH_MHI;
		end
		if (start && start_exh) begin
			res_valid = 1'b1;
			phase_n   = PH_IDLE;
		end else if (phase_base != PH_IDLE) begin
			count_n = count_inc;
			case (phase_base)
				PH_MHI: begin
					hold_n  = item.data_byte;
					phase_n = PH_MLO;
				end
				PH_MLO: begin
					marker_n = {hold_q, item.data_byte};
					if (marker_n == jhds_pkg::MARK_SOI || marker_n == jhds_pkg::MARK_EOI) begin
						phase_n  = PH_MHI;
						boundary = 1'b1;
					end else begin
						phase_n = PH_LHI;
					end
				end
				PH_LHI: begin
					hold_n  = item.data_byte;
					phase_n = PH_LLO;
				end
				PH_LLO: begin
					if (jhds_pkg::is_frame_marker(marker_q)) begin
						phase_n = PH_PREC;
					end else begin
						skip_n = len_skip;
						if (len_skip == 16'd0) begin
							phase_n  = PH_MHI;
							boundary = 1'b1;
						end else begin
							phase_n = PH_SKIP;
						end
					end
				end
				PH_SKIP: begin
					skip_n = skip_dec;
					if (skip_dec == 16'd0) begin
						phase_n  = PH_MHI;
						boundary = 1'b1;
					end
				end
				PH_PREC: phase_n = PH_HHI;
				PH_HHI: begin
					hold_n  = item.data_byte;
					phase_n = PH_HLO;
				end
				PH_HLO: begin
					height_n = {hold_q, item.data_byte};
					phase_n  = PH_WHI;
				end
				PH_WHI: begin
					hold_n  = item.data_byte;
					phase_n = PH_WLO;
				end
				PH_WLO: begin
					res_valid  = 1'b1;
					res.found  = 1'b1;
					res.height = height_q;
					res.width  = {hold_q, item.data_byte};
					phase_n    = PH_IDLE;
				end
				default: phase_n = PH_MHI;
			endcase
			// the last width byte wins even on the final byte
			if (phase_base != PH_WLO && ((boundary && bound_exh) || data_end)) begin
				res_valid = 1'b1;
				phase_n   = PH_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			count_q  <= '0;
			skip_q   <= '0;
			marker_q <= '0;
			hold_q   <= '0;
			height_q <= '0;
		end else if (en) begin
			phase_q  <= phase_n;
			count_q  <= count_n;
			skip_q   <= skip_n;
			marker_q <= marker_n;
			hold_q   <= hold_n;
			height_q <= height_n;
		end
	end

	a_idle_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		en && res_valid |=> phase_q == PH_IDLE)
		else $error("scan still active after its result");

	a_found_from_width: assert property (@(posedge clk) disable iff (!arst_n)
		en && res_valid && res.found |-> !start && phase_q == PH_WLO)
		else $error("found result outside the width byte");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		en && !start && phase_q != PH_IDLE |=> count_q >= $past(count_q))
		else $error("byte count went backwards within a scan");

	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		!start && phase_q == PH_IDLE |-> !res_valid)
		else $error("result without an active scan");

endmodule

[sv/jpeg_header_dimension_scanner.sv]
// Channel   Handshake                     Payload
// byte      byte_valid / byte_stall       byte_item   (data_byte, first_of_image)
// result    result_valid / result_stall   result_item (found, height, width)
// config    APB psel/penable/pwrite       image_bytes at byte address 0
//
// One byte per cycle sustained while no stalled result holds the flow; an accepted transfer
// passes through the input register, then the result register behind the scan logic.
// Reset clears the scan state, both valid flags and image_bytes.
// A stalled result holds the result register; the input register then holds
// too and byte_stall rises in the same cycle once that register is full.
module jpeg_header_dimension_scanner #(
	parameter int COUNT_BITS = jhds_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          byte_valid,
	output logic                          byte_stall,
	input  jhds_pkg::in_t                 byte_item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output jhds_pkg::out_t                result_item,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [jhds_pkg::ADDR_W-1:0]   paddr,
	input  logic [jhds_pkg::DATA_W-1:0]   pwdata,
	output logic [jhds_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	logic                                 valid_s1;
	jhds_pkg::in_t                        item_s1;
	logic                                 result_valid_q;
	jhds_pkg::out_t                       result_q;
	logic [jhds_pkg::IMAGE_BYTES_W-1:0]   image_bytes_q;
	logic                                 advance, take, res_valid;
	jhds_pkg::out_t                       res;

	assign advance    = !result_valid_q || !result_stall;
	assign byte_stall = valid_s1 && !advance;
	assign take       = byte_valid && !byte_stall;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == jhds_pkg::REG_IMAGE_BYTES) ?
		jhds_pkg::DATA_W'(image_bytes_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_bytes_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == jhds_pkg::REG_IMAGE_BYTES) begin
			image_bytes_q <= pwdata[jhds_pkg::IMAGE_BYTES_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= byte_item;
		end
	end

	jhds_parser #(
		.COUNT_BITS (COUNT_BITS)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (valid_s1 && advance),
		.item        (item_s1),
		.image_bytes (image_bytes_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result_item  = result_q;

endmodule

[tb/tb_jpeg_header_dimension_scanner.sv]
module tb_jpeg_header_dimension_scanner;
	import jhds_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_PCT = 31;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MARK_HI, ST_MARK_LO, ST_LEN_HI, ST_LEN_LO, ST_PREC,
		ST_HGT_HI, ST_HGT_LO, ST_WID_HI, ST_WID_LO, ST_SKIP
	} scan_state_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic byte_valid = 1'b0;
	logic byte_stall;
	in_t byte_item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	out_t result_item;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	jpeg_header_dimension_scanner i_dut (
		.clk(clk), .arst_n(arst_n),
		.byte_valid(byte_valid), .byte_stall(byte_stall), .byte_item(byte_item),
		.result_valid(result_valid), .result_stall(result_stall), .result_item(result_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	in_t pending_bytes[$];
	out_t expected_dims[$];
	int mismatches = 0;
	int cycles = 0;
	logic calm = 1'b0;
	logic hold_request = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;

	// scanner copy
	logic [23:0] image_bytes_cfg = '0;
	scan_state_e scan_ph = ST_IDLE;
	logic [23:0] seen_count = '0;
	logic [15:0] skip_left = '0;
	logic [15:0] marker = '0;
	logic [7:0] hi_byte = '0;
	logic [15:0] height_q = '0;
	logic scan_done = 1'b1;

	function automatic logic run_out();
		if (image_bytes_cfg < 24'd2)
			return 1'b1;
		return seen_count >= image_bytes_cfg - 24'd2;
	endfunction

	task automatic expect_miss();
		out_t r;
		r = '0;
		expected_dims.push_back(r);
		scan_done = 1'b1;
		scan_ph = ST_IDLE;
	endtask

	task automatic scan_byte(input in_t it);
		logic boundary;
		logic [15:0] len;
		out_t r;
		boundary = 1'b0;
		if (it.first_of_image) begin
			seen_count = '0;
			skip_left = '0;
			scan_done = 1'b0;
			scan_ph = ST_MARK_HI;
			if (run_out()) begin
				expect_miss();
				return;
			end
		end
		if (scan_done)
			return;
		if (seen_count != '1)
			seen_count = seen_count + 1'b1;
		case (scan_ph)
			ST_MARK_HI: begin
				hi_byte = it.data_byte;
				scan_ph = ST_MARK_LO;
			end
			ST_MARK_LO: begin
				marker = {hi_byte, it.data_byte};
				if (marker == MARK_SOI || marker == MARK_EOI) begin
					scan_ph = ST_MARK_HI;
					boundary = 1'b1;
				end else begin
					scan_ph = ST_LEN_HI;
				end
			end
			ST_LEN_HI: begin
				hi_byte = it.data_byte;
				scan_ph = ST_LEN_LO;
			end
			ST_LEN_LO: begin
				len = {hi_byte, it.data_byte};
				if (marker >= MARK_FRAME_LO && marker <= MARK_FRAME_HI &&
						marker != MARK_DHT && marker != MARK_JPG) begin
					scan_ph = ST_PREC;
				end else begin
					skip_left = (len >= 16'd2) ? len - 16'd2 : 16'd0;
					if (skip_left == 16'd0) begin
						scan_ph = ST_MARK_HI;
						boundary = 1'b1;
					end else begin
						scan_ph = ST_SKIP;
					end
				end
			end
			ST_SKIP: begin
				skip_left = skip_left - 16'd1;
				if (skip_left == 16'd0) begin
					scan_ph = ST_MARK_HI;
					boundary = 1'b1;
				end
			end
			ST_PREC: scan_ph = ST_HGT_HI;
			ST_HGT_HI: begin
				hi_byte = it.data_byte;
				scan_ph = ST_HGT_LO;
			end
			ST_HGT_LO: begin
				height_q = {hi_byte, it.data_byte};
				scan_ph = ST_WID_HI;
			end
			ST_WID_HI: begin
				hi_byte = it.data_byte;
				scan_ph = ST_WID_LO;
			end
			ST_WID_LO: begin
				r.found = 1'b1;
				r.height = height_q;
				r.width = {hi_byte, it.data_byte};
				expected_dims.push_back(r);
				scan_done = 1'b1;
				scan_ph = ST_IDLE;
				return;
			end
			default: scan_ph = ST_MARK_HI;
		endcase
		if (boundary && run_out()) begin
			expect_miss();
			return;
		end
		if (seen_count >= image_bytes_cfg)
			expect_miss();
	endtask

	// byte sender: hold the payload until the transfer completes
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && !byte_stall)
				scan_byte(byte_item);
			if (!byte_valid || !byte_stall) begin
				if (pending_bytes.size() != 0 &&
						(calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					byte_valid <= 1'b1;
					byte_item <= pending_bytes.pop_front();
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// result receiver with one long hold-off on request
	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_dims.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: found=%0b height=%h width=%h",
							result_item.found, result_item.height, result_item.width);
				end else begin
					want = expected_dims.pop_front();
					if (result_item.found !== want.found ||
							result_item.height !== want.height ||
							result_item.width !== want.width) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected found=%0b h=%h w=%h, got found=%0b h=%h w=%h",
								want.found, want.height, want.width,
								result_item.found, result_item.height, result_item.width);
					end
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (hold_request && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done <= 1'b1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("FAIL jpeg_header_dimension_scanner");
			$finish;
		end
	end

	task automatic write_image_bytes(input logic [23:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_IMAGE_BYTES, 2'b00};
		pwdata <= {8'h00, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		image_bytes_cfg = v;
	endtask

	task automatic put(input logic [7:0] b, input logic s);
		in_t it;
		it.data_byte = b;
		it.first_of_image = s;
		pending_bytes.push_back(it);
	endtask

	task automatic put_word(input logic [15:0] w);
		put(w[15:8], 1'b0);
		put(w[7:0], 1'b0);
	endtask

	task automatic drain();
		while (pending_bytes.size() != 0 || byte_valid || expected_dims.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_dim();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return 16'h0000;
		if (r < 4)
			return 16'hFFFF;
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 16'($urandom_range(0, 1));
		if (r < 11)
			return 16'h0100 + 16'($urandom_range(0, 63));
		return 16'($urandom_range(2, 8));
	endfunction

	task automatic gen_image();
		logic [15:0] w;
		logic [15:0] len;
		logic [7:0] code;
		logic [7:0] fr[9];
		logic [15:0] h;
		logic [15:0] wd;
		int cut;
		if ($urandom_range(0, 9) == 0) begin
			// noise: stray bytes, some restarting the scan
			repeat ($urandom_range(1, 6))
				put(8'($urandom), $urandom_range(0, 3) == 0);
			return;
		end
		put(8'hFF, 1'b1);
		put(8'hD8, 1'b0);
		repeat ($urandom_range(0, 3)) begin
			case ($urandom_range(0, 5))
				0: w = $urandom_range(0, 1) ? MARK_SOI : MARK_EOI;
				1: w = MARK_DHT;
				2: w = MARK_JPG;
				3: w = {8'hFF, 8'hE0 + 8'($urandom_range(0, 15))};
				default: w = 16'($urandom);
			endcase
			put_word(w);
			if (w != MARK_SOI && w != MARK_EOI) begin
				len = pick_len();
				put_word(len);
				if (len >= 16'd2)
					repeat (int'(len) - 2) put(8'($urandom), 1'b0);
			end
		end
		do code = 8'hC0 + 8'($urandom_range(0, 15));
		while (code == MARK_DHT[7:0] || code == MARK_JPG[7:0]);
		h = pick_dim();
		wd = pick_dim();
		fr[0] = 8'hFF;
		fr[1] = code;
		fr[2] = 8'($urandom);
		fr[3] = 8'($urandom);
		fr[4] = 8'($urandom);
		fr[5] = h[15:8];
		fr[6] = h[7:0];
		fr[7] = wd[15:8];
		fr[8] = wd[7:0];
		// cut some frames short; the next start abandons them
		cut = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 8) : 9;
		for (int i = 0; i < cut; i++)
			put(fr[i], 1'b0);
		repeat ($urandom_range(0, 2)) put(8'($urandom), 1'b0);
	endtask

	logic [23:0] phase_cfg[8];
	int target;

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value zero: stray byte ignored, start runs out at once
		put(8'h3C, 1'b0);
		put(8'hFF, 1'b1);
		drain();

		// data ends exactly on the last width byte; short and skipped segments on the way
		write_image_bytes(24'd20);
		put(8'hFF, 1'b1);
		put(8'hD8, 1'b0);
		put_word(MARK_DHT);
		put_word(16'h0001);
		put_word(MARK_JPG);
		put_word(16'h0003);
		put(8'hAA, 1'b0);
		put_word(MARK_FRAME_LO);
		put_word(16'h0011);
		put(8'h08, 1'b0);
		put_word(16'hFFFF);
		put_word(16'h0000);
		put(8'h55, 1'b0);
		drain();

		// tiny images
		write_image_bytes(24'd1);
		put(8'h00, 1'b1);
		drain();
		write_image_bytes(24'd2);
		put(8'hFF, 1'b1);
		drain();

		phase_cfg[0] = 24'hFFFFFF;
		phase_cfg[1] = 24'd3;
		phase_cfg[2] = 24'($urandom_range(8, 40));
		phase_cfg[3] = 24'hFFFFFF;
		phase_cfg[4] = 24'($urandom_range(12, 30));
		phase_cfg[5] = 24'($urandom_range(20, 60));
		phase_cfg[6] = 24'd1;
		phase_cfg[7] = 24'hFFFFFF;
		for (int p = 0; p < 8; p++) begin
			write_image_bytes(phase_cfg[p]);
			calm <= (p == 3);
			target = pending_bytes.size() + 90;
			while (pending_bytes.size() < target)
				gen_image();
			drain();
			calm <= 1'b0;
		end

		// every start byte gives a result; hold results off so the block backs up
		write_image_bytes(24'd2);
		hold_request <= 1'b1;
		repeat (80) put(8'($urandom), 1'b1);
		drain();

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("PASS jpeg_header_dimension_scanner");
		else
			$display("FAIL jpeg_header_dimension_scanner");
		$finish;
	end

endmodule
